>>> sv/msr_pkg.sv
// Package for the modular scale ratio block: widths, word types and FSM encoding.
package msr_pkg;

    // Width of moduli, residues and scales
    localparam int MOD_W = 31;
    // Width of the signed Bezout coefficients, with headroom for shifted copies
    localparam int COEF_W = MOD_W + 3;
    // Counter width for bit positions 0 .. MOD_W-1
    localparam int CNT_W = $clog2(MOD_W);
    // Reset value of the plaintext modulus
    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(65537);

    // Input word
    typedef struct packed {
        logic [MOD_W-1:0] target_scale;
        logic [MOD_W-1:0] source_scale;
    } item_t;

    // Result word
    typedef struct packed {
        logic [MOD_W-1:0] scale_factor;
        logic             not_invertible;
    } result_t;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REDUCE = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_ALIGN  = 7'b0001000,
        ST_SUB    = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

endpackage

>>> sv/modular_scale_ratio.sv
// Top level: bit-serial modular inverse of the source scale and multiply by the target scale.
//
//  channel   | signals                      | dir | handshake
//  ----------+------------------------------+-----+------------------------------------
//  item      | item (item_t)                | in  | taken when start & !busy
//  result    | result (result_t)            | out | valid for one cycle while done is high
//  config    | cfg_wdata (plain modulus)    | in  | written when cfg_we is high
//
// One word at a time. The steps are bit-serial reduction, then the Euclid loop (per quotient q:
// alignment shifts of the divisor, then one subtract step per quotient bit and a check, at
// most about 46 quotients), then a bit-serial modular multiply, then the done state that shows
// the result. A modulus below two goes straight to the done state in the cycle after the
// accepting edge.
// Reset sets the modulus to 65537 and returns the sequencer to idle.
// busy stays high from the accepting edge through the done cycle; the receiver cannot stall.
module modular_scale_ratio (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  msr_pkg::item_t           item,
    output logic                     busy,
    output logic                     done,
    output msr_pkg::result_t         result,
    input  logic                     cfg_we,
    input  logic [msr_pkg::MOD_W-1:0] cfg_wdata
);
    import msr_pkg::*;

    // One step of MSB-first reduction: (2r + b) mod m, with r < m
    function automatic logic [MOD_W-1:0] red_step(input logic [MOD_W-1:0] r,
                                                  input logic b,
                                                  input logic [MOD_W-1:0] m);
        logic [MOD_W:0] x;
        x = {r, b};
        if (x >= {1'b0, m})
            return MOD_W'(x - {1'b0, m});
        else
            return x[MOD_W-1:0];
    endfunction

    state_t                    state_reg, state_next;
    logic [MOD_W-1:0]          mod_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [MOD_W-1:0]          tsh_reg, tsh_next;
    logic [MOD_W-1:0]          ssh_reg, ssh_next;
    logic [MOD_W-1:0]          tgt_reg, tgt_next;
    logic [MOD_W:0]            ra_reg, ra_next;
    logic [MOD_W:0]            rb_reg, rb_next;
    logic [MOD_W:0]            dv_reg, dv_next;
    logic signed [COEF_W-1:0]  sa_reg, sa_next;
    logic signed [COEF_W-1:0]  sb_reg, sb_next;
    logic signed [COEF_W-1:0]  sd_reg, sd_next;
    logic [MOD_W-1:0]          inv_reg, inv_next;
    logic [MOD_W-1:0]          acc_reg, acc_next;
    logic                      ninv_reg, ninv_next;

    // Shared datapath terms
    logic [MOD_W+1:0]          mul_v;
    logic [MOD_W+1:0]          mod_x1;
    logic [MOD_W+1:0]          mod_x2;
    logic                      sub_ok;
    logic [MOD_W:0]            ra_sub;
    logic signed [COEF_W-1:0]  sa_sub;
    logic signed [COEF_W-1:0]  sa_fix;
    logic [CNT_W-1:0]          last_bit;

    assign last_bit = CNT_W'(MOD_W - 1);
    assign mod_x1   = {2'b00, mod_reg};
    assign mod_x2   = {1'b0, mod_reg, 1'b0};

    // Double-and-add term of the modular multiply, below 3t
    assign mul_v = {1'b0, acc_reg, 1'b0}
                 + (inv_reg[MOD_W-1] ? {2'b00, tgt_reg} : {(MOD_W+2){1'b0}});

    // Conditional subtract of the shifted divisor
    assign sub_ok = (dv_reg <= ra_reg);
    assign ra_sub = sub_ok ? (ra_reg - dv_reg) : ra_reg;
    assign sa_sub = sub_ok ? (sa_reg - sd_reg) : sa_reg;

    // Negative coefficient folded into [0, t)
    assign sa_fix = sa_reg[COEF_W-1] ? (sa_reg + $signed({3'b000, mod_reg})) : sa_reg;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tsh_next   = tsh_reg;
        ssh_next   = ssh_reg;
        tgt_next   = tgt_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        dv_next    = dv_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        sd_next    = sd_reg;
        inv_next   = inv_reg;
        acc_next   = acc_reg;
        ninv_next  = ninv_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mod_reg < MOD_W'(2))
                    begin
                        // Modulus out of range: zero result, flagged
                        acc_next   = '0;
                        ninv_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        tsh_next   = item.target_scale;
                        ssh_next   = item.source_scale;
                        tgt_next   = '0;
                        rb_next    = '0;
                        cnt_next   = '0;
                        state_next = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                // Both inputs reduced mod t, one bit per cycle
                tgt_next = red_step(tgt_reg, tsh_reg[MOD_W-1], mod_reg);
                rb_next  = {1'b0, red_step(rb_reg[MOD_W-1:0], ssh_reg[MOD_W-1], mod_reg)};
                tsh_next = {tsh_reg[MOD_W-2:0], 1'b0};
                ssh_next = {ssh_reg[MOD_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == last_bit)
                begin
                    ra_next    = {1'b0, mod_reg};
                    sa_next    = '0;
                    sb_next    = COEF_W'(1);
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (rb_reg == '0)
                begin
                    // Euclid finished: ra holds the gcd, sa the coefficient
                    ninv_next  = (ra_reg != (MOD_W+1)'(1));
                    inv_next   = (ra_reg == (MOD_W+1)'(1)) ? sa_fix[MOD_W-1:0] : '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    dv_next    = rb_reg;
                    sd_next    = sb_reg;
                    cnt_next   = '0;
                    state_next = ST_ALIGN;
                end
            end

            ST_ALIGN:
            begin
                // Shift the divisor up until its double would pass the remainder
                if ({dv_reg, 1'b0} <= {1'b0, ra_reg})
                begin
                    dv_next  = {dv_reg[MOD_W-1:0], 1'b0};
                    sd_next  = sd_reg <<< 1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end

            ST_SUB:
            begin
                // One quotient bit per cycle, coefficient updated alongside
                dv_next = dv_reg >> 1;
                sd_next = sd_reg >>> 1;
                if (cnt_reg == '0)
                begin
                    ra_next    = rb_reg;
                    rb_next    = ra_sub;
                    sa_next    = sb_reg;
                    sb_next    = sa_sub;
                    state_next = ST_CHECK;
                end
                else
                begin
                    ra_next  = ra_sub;
                    sa_next  = sa_sub;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            ST_MUL:
            begin
                // MSB-first double-and-add modulo t
                priority if (mul_v >= mod_x2)
                    acc_next = MOD_W'(mul_v - mod_x2);
                else if (mul_v >= mod_x1)
                    acc_next = MOD_W'(mul_v - mod_x1);
                else
                    acc_next = mul_v[MOD_W-1:0];
                inv_next = {inv_reg[MOD_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == last_bit)
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mod_reg   <= MOD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
                mod_reg <= cfg_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        tsh_reg  <= tsh_next;
        ssh_reg  <= ssh_next;
        tgt_reg  <= tgt_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        dv_reg   <= dv_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        sd_reg   <= sd_next;
        inv_reg  <= inv_next;
        acc_reg  <= acc_next;
        ninv_reg <= ninv_next;
    end

    // Outputs
    assign busy                  = (state_reg != ST_IDLE);
    assign done                  = (state_reg == ST_DONE);
    assign result.scale_factor   = acc_reg;
    assign result.not_invertible = ninv_reg;

    // An accepted word keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // Aligned divisor never exceeds the partial remainder
    a_align_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALIGN) |-> (dv_reg <= ra_reg))
        else $error("divisor aligned past remainder");

    // Euclid remainders strictly decrease
    a_rem_order: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CHECK) && (rb_reg != '0)) |-> (rb_reg < ra_reg))
        else $error("Euclid remainder out of order");

    // A flagged word carries a zero factor
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.not_invertible) |-> (result.scale_factor == '0))
        else $error("non-invertible word with nonzero factor");

endmodule
